// ----- rtl/coplanar_face_area_sum_unit_macros.svh -----
// Assertion macros used by the coplanar face area sum back part.
`ifndef COPLANAR_FACE_AREA_SUM_UNIT_MACROS_SVH
`define COPLANAR_FACE_AREA_SUM_UNIT_MACROS_SVH

// Same-cycle implication, sampled on clk, off while arst_n is low.
`define CFSA_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, sampled on clk, off while arst_n is low.
`define CFSA_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- rtl/cfsa_pkg.sv -----
// Shared types and constants of the coplanar face area sum unit.
`timescale 1ns / 1ps
package cfsa_pkg;

	// Configuration port
	localparam int CFG_IDX_W  = 8;
	localparam int CFG_DATA_W = 20;

	localparam logic [CFG_IDX_W-1:0] CFG_NORMAL_X = 8'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_NORMAL_Y = 8'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_NORMAL_Z = 8'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_POINT_X  = 8'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_POINT_Y  = 8'd4;
	localparam logic [CFG_IDX_W-1:0] CFG_POINT_Z  = 8'd5;
	localparam logic [CFG_IDX_W-1:0] CFG_DIST_TOL = 8'd6;
	localparam logic [CFG_IDX_W-1:0] CFG_NORM_TOL = 8'd7;

	// Register widths
	localparam int NORM_W  = 16;
	localparam int POINT_W = 20;
	localparam int DTOL_W  = 16;
	localparam int NTOL_W  = 15;

	// Reset values
	localparam logic [NORM_W-1:0] NORMAL_Z_RST = 16'd16384;
	localparam logic [DTOL_W-1:0] DIST_TOL_RST = 16'd51;
	localparam logic [NTOL_W-1:0] NORM_TOL_RST = 15'd16;

	// Q2.14 fraction bits, and quotient bits of a normal component
	localparam int FRAC  = 14;
	localparam int QBITS = 15;

	// Output word
	localparam int TOTAL_W     = 48;
	localparam int AREA_W      = 43;
	localparam int M_TDATA_W   = ((TOTAL_W + AREA_W + 7) / 8) * 8;

	typedef struct packed {
		logic [NORM_W-1:0]  normal_x;
		logic [NORM_W-1:0]  normal_y;
		logic [NORM_W-1:0]  normal_z;
		logic [POINT_W-1:0] point_x;
		logic [POINT_W-1:0] point_y;
		logic [POINT_W-1:0] point_z;
		logic [DTOL_W-1:0]  dist_tol;
		logic [NTOL_W-1:0]  norm_tol;
	} cfsa_cfg_t;

	typedef struct packed {
		logic full;
		logic empty;
	} cfsa_q_status_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_MUL,
		ST_DRAIN,
		ST_SQRT,
		ST_DIVINIT,
		ST_DIV,
		ST_FIN
	} cfsa_state_t;

	// Shared multiplier schedule, one product per cycle
	typedef enum logic [4:0] {
		OP_YZ,
		OP_ZY,
		OP_ZX,
		OP_XZ,
		OP_XY,
		OP_YX,
		OP_DX,
		OP_DY,
		OP_DZ,
		OP_SQ0_HH,
		OP_SQ0_HL,
		OP_SQ0_LL,
		OP_SQ1_HH,
		OP_SQ1_HL,
		OP_SQ1_LL,
		OP_SQ2_HH,
		OP_SQ2_HL,
		OP_SQ2_LL
	} cfsa_mul_op_t;

endpackage

// ----- rtl/cfsa_fifo.sv -----
// Two-entry queue between the front and back parts.
`timescale 1ns / 1ps
module cfsa_fifo #(
	parameter int WIDTH = 8
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    push,
	input  logic [WIDTH-1:0]        push_data,
	input  logic                    pop,
	output logic [WIDTH-1:0]        pop_data,
	output cfsa_pkg::cfsa_q_status_t status
);
	import cfsa_pkg::*;

	logic [WIDTH-1:0] mem_q [2];
	logic             wr_ptr_q;
	logic             rd_ptr_q;
	logic [1:0]       cnt_q;

	assign status.full  = (cnt_q == 2'd2);
	assign status.empty = (cnt_q == 2'd0);
	assign pop_data     = mem_q[rd_ptr_q];

	// storage
	always_ff @(posedge clk) begin
		if (push)
			mem_q[wr_ptr_q] <= push_data;
	end

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			cnt_q    <= 2'd0;
		end else begin
			if (push)
				wr_ptr_q <= ~wr_ptr_q;
			if (pop)
				rd_ptr_q <= ~rd_ptr_q;
			if (push && !pop)
				cnt_q <= cnt_q + 2'd1;
			else if (pop && !push)
				cnt_q <= cnt_q - 2'd1;
		end
	end

endmodule

// ----- rtl/cfsa_front.sv -----
// Front part: takes triangle words, forms edge vectors and plane offsets.
`timescale 1ns / 1ps
module cfsa_front #(
	parameter int COORD_BITS = 20,
	parameter int CW         = 20,
	parameter int EW         = 21,
	parameter int PL_W       = 1 + 9 * 21
) (
	input  logic                     s_tvalid,
	output logic                     s_tready,
	input  logic [9*COORD_BITS-1:0]  s_tdata,
	input  logic                     s_tuser,
	input  cfsa_pkg::cfsa_cfg_t      cfg,
	input  cfsa_pkg::cfsa_q_status_t q_status,
	output logic                     push,
	output logic [PL_W-1:0]          push_data
);
	import cfsa_pkg::*;

	localparam int PW = (CW < POINT_W) ? CW : POINT_W;

	logic signed [EW-1:0] v [9];
	logic signed [EW-1:0] pt [3];
	logic [POINT_W-1:0]   praw [3];

	assign s_tready = !q_status.full;
	assign push     = s_tvalid && s_tready;

	assign praw[0] = cfg.point_x;
	assign praw[1] = cfg.point_y;
	assign praw[2] = cfg.point_z;

	// vertices at CW bits, sign extended
	always_comb begin
		for (int k = 0; k < 9; k++)
			v[k] = EW'(signed'(s_tdata[k*COORD_BITS +: CW]));
	end

	// plane point at coordinate width; a wider coordinate sees it unsigned
	always_comb begin
		for (int i = 0; i < 3; i++) begin
			if (CW > POINT_W)
				pt[i] = EW'({1'b0, praw[i]});
			else
				pt[i] = EW'(signed'(praw[i][PW-1:0]));
		end
	end

	// queue word: flag, edge b-a, edge c-a, offset a-P
	always_comb begin
		push_data    = '0;
		push_data[0] = s_tuser;
		for (int i = 0; i < 3; i++) begin
			push_data[1 + i*EW +: EW]       = v[3+i] - v[i];
			push_data[1 + (3+i)*EW +: EW]   = v[6+i] - v[i];
			push_data[1 + (6+i)*EW +: EW]   = v[i] - pt[i];
		end
	end

endmodule

// ----- rtl/cfsa_back.sv -----
// Back part: cross product, plane distance, square root, normal division and area total.
`timescale 1ns / 1ps
`include "coplanar_face_area_sum_unit_macros.svh"
module cfsa_back #(
	parameter int EW       = 21,
	parameter int PL_W     = 1 + 9 * 21,
	parameter int ACC_BITS = 48
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  cfsa_pkg::cfsa_cfg_t          cfg,
	input  cfsa_pkg::cfsa_q_status_t     q_status,
	input  logic [PL_W-1:0]              q_data,
	output logic                         q_pop,
	output logic                         m_tvalid,
	input  logic                         m_tready,
	output logic [cfsa_pkg::M_TDATA_W-1:0] m_tdata,
	output logic                         m_tuser
);
	import cfsa_pkg::*;

	localparam int CRW   = 2 * EW + 1;
	localparam int LOW   = EW + 1;
	localparam int MW    = (EW + 2 > 17) ? EW + 2 : 17;
	localparam int L2W   = 2 * CRW + 2;
	localparam int SW    = L2W / 2;
	localparam int DW    = EW + NORM_W + 2;
	localparam int NW    = CRW + FRAC + 1;
	localparam int RW    = SW + 1;
	localparam int CNT_W = $clog2(SW + 1);
	localparam int ACCX  = ((ACC_BITS > SW) ? ACC_BITS : SW) + 1;
	localparam int DIFW  = NORM_W + 2;

	cfsa_state_t  state_q, state_d;
	cfsa_mul_op_t step_q;
	logic [CNT_W-1:0] cnt_q;

	logic [PL_W-1:0] pl_q;
	logic signed [2*MW-1:0] prod_s1;
	cfsa_mul_op_t           prod_op_s1;
	logic                   prod_vld_s1;
	logic signed [2*MW-1:0] t_q;
	logic signed [CRW-1:0]  cr_q [3];
	logic signed [DW-1:0]   dist_q;
	logic [L2W-1:0]         l2_q;
	logic [SW+1:0]          rem_q;
	logic [SW-1:0]          root_q;
	logic [NW-1:0]          num_q [3];
	logic [RW-1:0]          drem_q [3];
	logic [QBITS-1:0]       quo_q [3];
	logic [ACC_BITS-1:0]    acc_q;
	logic                   m_valid_q;
	logic [TOTAL_W-1:0]     tot_q;
	logic [AREA_W-1:0]      area_q;
	logic                   cnt_flag_q;

	logic signed [EW-1:0]   e1 [3];
	logic signed [EW-1:0]   e2 [3];
	logic signed [EW-1:0]   dd [3];
	logic                   pl_ff;
	logic [CRW-1:0]         mag [3];
	logic signed [MW-1:0]   opa, opb;
	logic [CRW-1:0]         sq_mag;
	logic [EW-1:0]          sq_hi;
	logic [LOW-1:0]         sq_lo;
	logic                   issue;
	logic                   out_free;
	logic                   out_load;
	logic [SW+1:0]          rem_n, trial;
	logic [NW-1:0]          num_n [3];
	logic [RW:0]            r2 [3];
	logic                   n_ok [3];
	logic                   dist_ok;
	logic                   counted_c;
	logic [DW-1:0]          dmag;
	logic [SW-2:0]          area_c;
	logic [ACC_BITS-1:0]    base_c;
	logic [ACCX-1:0]        sum_c;
	logic [ACC_BITS-1:0]    acc_next;
	logic [63:0]            acc64, area64;
	logic [NORM_W-1:0]      nreg [3];

	assign nreg[0] = cfg.normal_x;
	assign nreg[1] = cfg.normal_y;
	assign nreg[2] = cfg.normal_z;

	// unpack the held queue word
	assign pl_ff = pl_q[0];
	always_comb begin
		for (int i = 0; i < 3; i++) begin
			e1[i] = signed'(pl_q[1 + i*EW +: EW]);
			e2[i] = signed'(pl_q[1 + (3+i)*EW +: EW]);
			dd[i] = signed'(pl_q[1 + (6+i)*EW +: EW]);
			mag[i] = cr_q[i][CRW-1] ? CRW'(-cr_q[i]) : CRW'(cr_q[i]);
		end
	end

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE:    if (!q_status.empty) state_d = ST_MUL;
			ST_MUL:     if (step_q == OP_SQ2_LL) state_d = ST_DRAIN;
			ST_DRAIN:   state_d = ST_SQRT;
			ST_SQRT:    if (cnt_q == CNT_W'(SW - 1)) state_d = ST_DIVINIT;
			ST_DIVINIT: state_d = ST_DIV;
			ST_DIV:     if (cnt_q == CNT_W'(QBITS - 1)) state_d = ST_FIN;
			ST_FIN:     if (out_free) state_d = ST_IDLE;
			default:    state_d = ST_IDLE;
		endcase
	end

	// state outputs
	assign out_free = !m_valid_q || m_tready;
	always_comb begin
		q_pop    = 1'b0;
		issue    = 1'b0;
		out_load = 1'b0;
		unique case (state_q)
			ST_IDLE: q_pop    = !q_status.empty;
			ST_MUL:  issue    = 1'b1;
			ST_FIN:  out_load = out_free;
			default: ;
		endcase
	end

	// multiplier operand select
	always_comb begin
		case (step_q)
			OP_SQ0_HH, OP_SQ0_HL, OP_SQ0_LL: sq_mag = mag[0];
			OP_SQ1_HH, OP_SQ1_HL, OP_SQ1_LL: sq_mag = mag[1];
			default:                         sq_mag = mag[2];
		endcase
		sq_hi = sq_mag[CRW-1:LOW];
		sq_lo = sq_mag[LOW-1:0];
		case (step_q)
			OP_YZ: begin opa = MW'(e1[1]); opb = MW'(e2[2]); end
			OP_ZY: begin opa = MW'(e1[2]); opb = MW'(e2[1]); end
			OP_ZX: begin opa = MW'(e1[2]); opb = MW'(e2[0]); end
			OP_XZ: begin opa = MW'(e1[0]); opb = MW'(e2[2]); end
			OP_XY: begin opa = MW'(e1[0]); opb = MW'(e2[1]); end
			OP_YX: begin opa = MW'(e1[1]); opb = MW'(e2[0]); end
			OP_DX: begin opa = MW'(dd[0]); opb = MW'(signed'(nreg[0])); end
			OP_DY: begin opa = MW'(dd[1]); opb = MW'(signed'(nreg[1])); end
			OP_DZ: begin opa = MW'(dd[2]); opb = MW'(signed'(nreg[2])); end
			OP_SQ0_HH, OP_SQ1_HH, OP_SQ2_HH: begin
				opa = signed'(MW'(sq_hi));
				opb = signed'(MW'(sq_hi));
			end
			OP_SQ0_HL, OP_SQ1_HL, OP_SQ2_HL: begin
				opa = signed'(MW'(sq_hi));
				opb = signed'(MW'(sq_lo));
			end
			default: begin
				opa = signed'(MW'(sq_lo));
				opb = signed'(MW'(sq_lo));
			end
		endcase
	end

	// square root step: two radicand bits in, one root bit out
	assign rem_n = {rem_q[SW-1:0], l2_q[L2W-1 -: 2]};
	assign trial = {root_q, 2'b01};

	// division step setup and one quotient bit per lane
	always_comb begin
		for (int i = 0; i < 3; i++) begin
			num_n[i] = (NW'(mag[i]) << FRAC) + NW'(root_q >> 1);
			r2[i]    = {drem_q[i], num_q[i][QBITS-1]};
		end
	end

	// plane tests and saturating total
	always_comb begin
		logic signed [QBITS:0]  q;
		logic signed [DIFW-1:0] d;
		logic [DIFW-1:0]        dm;
		for (int i = 0; i < 3; i++) begin
			q = signed'({1'b0, quo_q[i]});
			if (cr_q[i][CRW-1])
				q = -q;
			d  = DIFW'(signed'(nreg[i])) - DIFW'(q);
			dm = d[DIFW-1] ? DIFW'(-d) : DIFW'(d);
			n_ok[i] = dm < DIFW'(cfg.norm_tol);
		end
		dmag      = dist_q[DW-1] ? DW'(-dist_q) : DW'(dist_q);
		dist_ok   = 64'(dmag) <= (64'(cfg.dist_tol) << FRAC);
		counted_c = (root_q != '0) && dist_ok && n_ok[0] && n_ok[1] && n_ok[2];
		area_c    = root_q[SW-1:1];
		base_c    = pl_ff ? '0 : acc_q;
		sum_c     = ACCX'(base_c) + ACCX'(area_c);
		if (!counted_c)
			acc_next = base_c;
		else if (sum_c > ACCX'({ACC_BITS{1'b1}}))
			acc_next = {ACC_BITS{1'b1}};
		else
			acc_next = sum_c[ACC_BITS-1:0];
		acc64  = 64'(acc_next);
		area64 = 64'(area_c);
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			step_q      <= OP_YZ;
			cnt_q       <= '0;
			prod_vld_s1 <= 1'b0;
			m_valid_q   <= 1'b0;
			acc_q       <= '0;
		end else begin
			state_q     <= state_d;
			prod_vld_s1 <= issue;
			if (state_q == ST_IDLE)
				step_q <= OP_YZ;
			else if (issue && step_q != OP_SQ2_LL)
				step_q <= cfsa_mul_op_t'(step_q + 5'd1);
			if (state_q == ST_DRAIN || state_q == ST_DIVINIT)
				cnt_q <= '0;
			else if (state_q == ST_SQRT || state_q == ST_DIV)
				cnt_q <= cnt_q + CNT_W'(1);
			if (out_load) begin
				m_valid_q <= 1'b1;
				acc_q     <= acc_next;
			end else if (m_tready) begin
				m_valid_q <= 1'b0;
			end
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		if (q_pop) begin
			pl_q <= q_data;
			l2_q <= '0;
		end
		if (issue) begin
			prod_s1    <= opa * opb;
			prod_op_s1 <= step_q;
		end
		// consume the product issued in the previous cycle
		if (prod_vld_s1) begin
			case (prod_op_s1)
				OP_YZ, OP_ZX, OP_XY: t_q <= prod_s1;
				OP_ZY: cr_q[0] <= CRW'(t_q - prod_s1);
				OP_XZ: cr_q[1] <= CRW'(t_q - prod_s1);
				OP_YX: cr_q[2] <= CRW'(t_q - prod_s1);
				OP_DX: dist_q <= DW'(prod_s1);
				OP_DY, OP_DZ: dist_q <= dist_q + DW'(prod_s1);
				OP_SQ0_HH, OP_SQ1_HH, OP_SQ2_HH:
					l2_q <= l2_q + (L2W'(unsigned'(prod_s1)) << (2 * LOW));
				OP_SQ0_HL, OP_SQ1_HL, OP_SQ2_HL:
					l2_q <= l2_q + (L2W'(unsigned'(prod_s1)) << (LOW + 1));
				default:
					l2_q <= l2_q + L2W'(unsigned'(prod_s1));
			endcase
		end
		if (state_q == ST_DRAIN) begin
			rem_q  <= '0;
			root_q <= '0;
		end
		if (state_q == ST_SQRT) begin
			l2_q <= l2_q << 2;
			if (rem_n >= trial) begin
				rem_q  <= rem_n - trial;
				root_q <= {root_q[SW-2:0], 1'b1};
			end else begin
				rem_q  <= rem_n;
				root_q <= {root_q[SW-2:0], 1'b0};
			end
		end
		for (int i = 0; i < 3; i++) begin
			if (state_q == ST_DIVINIT) begin
				num_q[i]  <= num_n[i];
				drem_q[i] <= RW'(num_n[i] >> QBITS);
				quo_q[i]  <= '0;
			end
			if (state_q == ST_DIV) begin
				num_q[i] <= num_q[i] << 1;
				if (r2[i] >= (RW+1)'(root_q)) begin
					drem_q[i] <= RW'(r2[i] - (RW+1)'(root_q));
					quo_q[i]  <= {quo_q[i][QBITS-2:0], 1'b1};
				end else begin
					drem_q[i] <= RW'(r2[i]);
					quo_q[i]  <= {quo_q[i][QBITS-2:0], 1'b0};
				end
			end
		end
		if (out_load) begin
			tot_q      <= acc64[TOTAL_W-1:0];
			area_q     <= area64[AREA_W-1:0];
			cnt_flag_q <= counted_c;
		end
	end

	assign m_tvalid = m_valid_q;
	assign m_tdata  = M_TDATA_W'({area_q, tot_q});
	assign m_tuser  = cnt_flag_q;

	`CFSA_ASSERT_IMP(a_pop_nonempty, q_pop, !q_status.empty, "pop from empty queue")
	`CFSA_ASSERT_IMP(a_load_in_fin, out_load, state_q == ST_FIN, "result loaded outside finish")
	`CFSA_ASSERT_IMP(a_idle_no_prod, state_q == ST_IDLE, !prod_vld_s1, "product pending in idle")
	`CFSA_ASSERT_NXT(a_acc_hold, out_load && !counted_c && !pl_ff, acc_q == $past(acc_q), "total moved without a counted face")

endmodule

// ----- rtl/coplanar_face_area_sum_unit.sv -----
// Top level of the coplanar face area sum unit.
`timescale 1ns / 1ps
// Each input word is one triangle; each triangle gives one output word holding the running
// coplanar area total, this triangle's area and a counted flag. In the back end a triangle
// takes 18 issues of the shared multiplier for the cross product, plane distance and
// squared length, one bit per cycle of the square root over CW*2+4 steps, with CW =
// min(COORD_BITS, 21), and 15 steps of the three normal-component dividers. A two-word
// queue lets the input side accept while the back end is busy or a result waits in the
// output register. Configuration is written through the cfg channel, always ready; the user
// must write it only while the unit is idle, and the block itself does not enforce this.
module coplanar_face_area_sum_unit #(
	parameter int COORD_BITS = 20,
	parameter int ACC_BITS   = 48
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	// tdata: vert_a_x, vert_a_y, vert_a_z, vert_b_x, vert_b_y, vert_b_z,
	//        vert_c_x, vert_c_y, vert_c_z (COORD_BITS each), zero pad
	input  logic                                 s_tvalid,
	output logic                                 s_tready,
	input  logic [((9*COORD_BITS+7)/8)*8-1:0]    s_tdata,
	// tuser: first_face
	input  logic                                 s_tuser,
	// tdata: area_total[47:0], face_area[90:48], zero pad
	output logic                                 m_tvalid,
	input  logic                                 m_tready,
	output logic [cfsa_pkg::M_TDATA_W-1:0]       m_tdata,
	// tuser: face_counted
	output logic                                 m_tuser,
	input  logic                                 cfg_valid,
	output logic                                 cfg_ready,
	input  logic [cfsa_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  logic [cfsa_pkg::CFG_DATA_W-1:0]      cfg_data
);
	import cfsa_pkg::*;

	localparam int CW   = (COORD_BITS > 21) ? 21 : COORD_BITS;
	localparam int EW   = CW + 1;
	localparam int PL_W = 1 + 9 * EW;

	cfsa_cfg_t      cfg_q;
	cfsa_q_status_t q_status;
	logic           push, pop;
	logic [PL_W-1:0] push_data, pop_data;

	assign cfg_ready = 1'b1;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '{normal_x: '0, normal_y: '0, normal_z: NORMAL_Z_RST,
				point_x: '0, point_y: '0, point_z: '0,
				dist_tol: DIST_TOL_RST, norm_tol: NORM_TOL_RST};
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				CFG_NORMAL_X: cfg_q.normal_x <= cfg_data[NORM_W-1:0];
				CFG_NORMAL_Y: cfg_q.normal_y <= cfg_data[NORM_W-1:0];
				CFG_NORMAL_Z: cfg_q.normal_z <= cfg_data[NORM_W-1:0];
				CFG_POINT_X:  cfg_q.point_x  <= cfg_data[POINT_W-1:0];
				CFG_POINT_Y:  cfg_q.point_y  <= cfg_data[POINT_W-1:0];
				CFG_POINT_Z:  cfg_q.point_z  <= cfg_data[POINT_W-1:0];
				CFG_DIST_TOL: cfg_q.dist_tol <= cfg_data[DTOL_W-1:0];
				CFG_NORM_TOL: cfg_q.norm_tol <= cfg_data[NTOL_W-1:0];
				default: ;
			endcase
		end
	end

	cfsa_front #(
		.COORD_BITS (COORD_BITS),
		.CW         (CW),
		.EW         (EW),
		.PL_W       (PL_W)
	) u_front (
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata[9*COORD_BITS-1:0]),
		.s_tuser   (s_tuser),
		.cfg       (cfg_q),
		.q_status  (q_status),
		.push      (push),
		.push_data (push_data)
	);

	cfsa_fifo #(
		.WIDTH (PL_W)
	) u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (push_data),
		.pop       (pop),
		.pop_data  (pop_data),
		.status    (q_status)
	);

	cfsa_back #(
		.EW       (EW),
		.PL_W     (PL_W),
		.ACC_BITS (ACC_BITS)
	) u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg      (cfg_q),
		.q_status (q_status),
		.q_data   (pop_data),
		.q_pop    (pop),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser)
	);

endmodule

// ----- dv/tb_coplanar_face_area_sum_unit.sv -----
// Testbench for the coplanar face area sum unit: self-checking, random stalls on both sides.
`timescale 1ns / 1ps
module tb_coplanar_face_area_sum_unit;
	import cfsa_pkg::*;

	localparam int CB = 20;
	localparam int S_W = ((9*CB+7)/8)*8;
	localparam logic [TOTAL_W-1:0] TOTAL_MAX = '1;

	typedef struct {
		logic [TOTAL_W-1:0] total;
		logic [AREA_W-1:0]  area;
		logic               counted;
	} face_result_t;

	// Area predictor and store of pending face results
	class face_area_board;
		logic [NORM_W-1:0]  nrm[3];
		logic [POINT_W-1:0] pnt[3];
		logic [DTOL_W-1:0]  dtol;
		logic [NTOL_W-1:0]  ntol;
		logic [TOTAL_W-1:0] acc;
		face_result_t       pending[$];
		int errors, faces, counted, saturated;

		function new();
			nrm = '{16'd0, 16'd0, NORMAL_Z_RST};
			pnt = '{20'd0, 20'd0, 20'd0};
			dtol = DIST_TOL_RST;
			ntol = NORM_TOL_RST;
			acc = '0;
			errors = 0; faces = 0; counted = 0; saturated = 0;
		endfunction

		function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] d);
			case (idx)
				CFG_NORMAL_X: nrm[0] = d[NORM_W-1:0];
				CFG_NORMAL_Y: nrm[1] = d[NORM_W-1:0];
				CFG_NORMAL_Z: nrm[2] = d[NORM_W-1:0];
				CFG_POINT_X:  pnt[0] = d;
				CFG_POINT_Y:  pnt[1] = d;
				CFG_POINT_Z:  pnt[2] = d;
				CFG_DIST_TOL: dtol = d[DTOL_W-1:0];
				CFG_NORM_TOL: ntol = d[NTOL_W-1:0];
				default: ;
			endcase
		endfunction

		function longint unsigned mag(longint v);
			return (v < 0) ? longint'(-v) : v;
		endfunction

		// rounded unit-normal component against the reference, halves away from zero
		function bit comp_close(longint comp, longint unsigned len, logic [NORM_W-1:0] ref_n);
			longint unsigned m;
			longint q, d;
			m = mag(comp) << FRAC;
			q = longint'((m + len / 2) / len);
			if (comp < 0) q = -q;
			d = longint'($signed(ref_n)) - q;
			return mag(d) < longint'(ntol);
		endfunction

		function void note(logic [S_W-1:0] d, logic ff);
			longint a[3], b[3], c[3], e1[3], e2[3], cr[3], plane_off;
			logic [127:0] len2, t2;
			longint unsigned len, t, area;
			face_result_t r;
			bit ok;
			for (int i = 0; i < 3; i++) begin
				a[i] = longint'($signed(d[CB*i +: CB]));
				b[i] = longint'($signed(d[CB*(i+3) +: CB]));
				c[i] = longint'($signed(d[CB*(i+6) +: CB]));
				e1[i] = b[i] - a[i];
				e2[i] = c[i] - a[i];
			end
			cr[0] = e1[1]*e2[2] - e1[2]*e2[1];
			cr[1] = e1[2]*e2[0] - e1[0]*e2[2];
			cr[2] = e1[0]*e2[1] - e1[1]*e2[0];
			len2 = '0;
			for (int i = 0; i < 3; i++) begin
				t2 = 128'(mag(cr[i]));
				len2 = len2 + t2 * t2;
			end
			// integer square root, bit by bit
			len = 0;
			for (int k = 63; k >= 0; k--) begin
				t = len | (64'd1 << k);
				t2 = 128'(t);
				if (t2 * t2 <= len2) len = t;
			end
			area = len >> 1;
			if (ff) acc = '0;
			plane_off = 0;
			for (int i = 0; i < 3; i++)
				plane_off += (a[i] - longint'($signed(pnt[i]))) * longint'($signed(nrm[i]));
			ok = len != 0 && mag(plane_off) <= (longint'(dtol) << FRAC);
			if (ok)
				for (int i = 0; i < 3; i++)
					ok = ok && comp_close(cr[i], len, nrm[i]);
			if (ok) begin
				if (area > longint'(TOTAL_MAX - acc)) begin
					acc = TOTAL_MAX;
					saturated++;
				end else
					acc = TOTAL_W'(acc + area);
				counted++;
			end
			faces++;
			r.total = acc;
			r.area = area[AREA_W-1:0];
			r.counted = ok;
			pending = {pending, r};
		endfunction

		task report(string what, longint unsigned got, longint unsigned want);
			errors++;
			$display("MISMATCH %s: got %0d, want %0d", what, got, want);
		endtask

		task check(logic [M_TDATA_W-1:0] d, logic cnt);
			face_result_t r;
			if (pending.size() == 0) begin
				report("unexpected word", d[TOTAL_W-1:0], 0);
			end else begin
				r = pending.pop_front();
				if (d[TOTAL_W-1:0] !== r.total)
					report("area_total", d[TOTAL_W-1:0], r.total);
				if (d[TOTAL_W +: AREA_W] !== r.area)
					report("face_area", d[TOTAL_W +: AREA_W], r.area);
				if (cnt !== r.counted)
					report("face_counted", cnt, r.counted);
			end
		endtask
	endclass

	logic clk, arst_n;
	logic s_tvalid, s_tready, s_tuser;
	logic [S_W-1:0] s_tdata;
	logic m_tvalid, m_tready, m_tuser;
	logic [M_TDATA_W-1:0] m_tdata;
	logic cfg_valid, cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;

	face_area_board board = new();
	logic [CB-1:0] vtx[9];
	int burst_left, hold_req;

	coplanar_face_area_sum_unit dut (.*);

	always begin
		clk = 1'b1; #2;
		clk = 1'b0; #2;
	end

	// Observe every handshake at the clock edge
	always @(posedge clk) begin
		if (arst_n) begin
			if (s_tvalid && s_tready) board.note(s_tdata, s_tuser);
			if (m_tvalid && m_tready) board.check(m_tdata, m_tuser);
			if (cfg_valid && cfg_ready) board.write_reg(cfg_index, cfg_data);
		end
	end

	// Receiver: rotating stall pattern, reloaded now and then, plus long holds on request
	logic [15:0] stall_pat;
	int pat_age, long_hold;
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tready <= 1'b0;
			stall_pat <= 16'hFFFF;
			pat_age = 0;
			long_hold = 0;
		end else if (hold_req != 0) begin
			hold_req = 0;
			long_hold = 400;
			m_tready <= 1'b0;
		end else if (long_hold > 0) begin
			long_hold--;
			m_tready <= 1'b0;
		end else begin
			pat_age++;
			if (pat_age >= 64) begin
				pat_age = 0;
				stall_pat <= ($urandom_range(3) == 0) ? 16'hFFFF : 16'($urandom() | $urandom());
			end else
				stall_pat <= {stall_pat[0], stall_pat[15:1]};
			m_tready <= stall_pat[0];
		end
	end

	function int rnd_s(int span);
		return int'($urandom_range(2*span)) - span;
	endfunction

	function logic [CB-1:0] clamp(int v);
		if (v > 524287) return 20'd524287;
		if (v < -524288) return 20'h80000;
		return v[CB-1:0];
	endfunction

	// One register write; valid stays up for the next write of a set
	task cfg_write(logic [CFG_IDX_W-1:0] idx, int d);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= d[CFG_DATA_W-1:0];
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
	endtask

	task wait_drained();
		while (board.pending.size() != 0) @(posedge clk);
		repeat (100) @(posedge clk);
	endtask

	// Full register set; only called with the unit idle
	task set_plane(int nx, int ny, int nz, int px, int py, int pz, int dt, int nt);
		wait_drained();
		cfg_write(CFG_NORMAL_X, nx);
		cfg_write(CFG_NORMAL_Y, ny);
		cfg_write(CFG_NORMAL_Z, nz);
		cfg_write(CFG_POINT_X, px);
		cfg_write(CFG_POINT_Y, py);
		cfg_write(CFG_POINT_Z, pz);
		cfg_write(CFG_DIST_TOL, dt);
		cfg_write(CFG_NORM_TOL, nt);
		cfg_valid <= 1'b0;
	endtask

	// One triangle from vtx; valid stays up inside a burst, drops for the gaps
	task send_tri(logic ff);
		int gap;
		s_tvalid <= 1'b1;
		s_tuser <= ff;
		s_tdata <= {4'b0, vtx[8], vtx[7], vtx[6], vtx[5], vtx[4], vtx[3], vtx[2], vtx[1],
			vtx[0]};
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		burst_left--;
		if (burst_left <= 0) begin
			burst_left = $urandom_range(1, 24);
			gap = $urandom_range(1, 10);
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	task end_burst();
		s_tvalid <= 1'b0;
		@(posedge clk);
	endtask

	task set_vtx(int ax, int ay, int az, int bx, int by, int bz, int cx, int cy, int cz);
		vtx = '{clamp(ax), clamp(ay), clamp(az), clamp(bx), clamp(by), clamp(bz),
			clamp(cx), clamp(cy), clamp(cz)};
	endtask

	// Triangle lying in the configured plane (axis of the largest normal component),
	// with a little tilt and offset so the tolerance edges get hit
	task gen_flat(int span, int tilt);
		int ax, best, base, lim, pv;
		ax = 0; best = -1;
		for (int i = 0; i < 3; i++) begin
			pv = $signed(board.nrm[i]);
			if ((pv < 0 ? -pv : pv) > best) begin
				best = pv < 0 ? -pv : pv;
				ax = i;
			end
		end
		lim = int'(board.dtol) + 2;
		if (lim > 4000) lim = 4000;
		base = $signed(board.pnt[ax]) + rnd_s(lim);
		for (int k = 0; k < 3; k++)
			for (int i = 0; i < 3; i++)
				vtx[3*k+i] = clamp(i == ax ? base + (k > 0 ? rnd_s(tilt) : 0) : rnd_s(span));
	endtask

	task gen_noise();
		for (int i = 0; i < 9; i++) vtx[i] = CB'($urandom());
	endtask

	task random_items(int n);
		for (int j = 0; j < n; j++) begin
			case ($urandom_range(9))
				0, 1: gen_noise();
				2: gen_flat(524287, $urandom_range(3));
				3: gen_flat(64, $urandom_range(4));
				default: gen_flat($urandom_range(1, 20000), $urandom_range(2) == 0 ? 40 : 0);
			endcase
			send_tri($urandom_range(15) == 0);
		end
		end_burst();
	endtask

	initial begin
		#4000000;
		$display("DONE: errors detected");
		$finish;
	end

	initial begin
		arst_n = 1'b0;
		s_tvalid = 1'b0; s_tuser = 1'b0; s_tdata = '0;
		cfg_valid = 1'b0; cfg_index = '0; cfg_data = '0;
		hold_req = 0;
		burst_left = 8;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed faces at reset settings: z plane through the origin
		set_vtx(0, 0, 0, 0, 0, 0, 0, 0, 0);               send_tri(1); // all zero, degenerate
		set_vtx(0, 0, 0, 100, 100, 0, 200, 200, 0);       send_tri(0); // collinear
		set_vtx(0, 0, 0, 256, 0, 0, 0, 256, 0);           send_tri(0); // counted
		set_vtx(0, 0, 0, 0, 256, 0, 256, 0, 0);           send_tri(0); // facing down
		set_vtx(0, 0, 51, 256, 0, 51, 0, 256, 51);        send_tri(0); // at distance limit
		set_vtx(0, 0, 52, 256, 0, 52, 0, 256, 52);        send_tri(0); // just too far
		set_vtx(0, 0, -51, 512, 0, -51, 0, 512, -51);     send_tri(1); // first face, below
		set_vtx(0, 0, 0, 256, 0, 0, 0, 0, 256);           send_tri(0); // vertical, normal fails
		set_vtx(0, 0, 0, 4096, 0, 0, 0, 4096, 3);         send_tri(0); // slight tilt
		set_vtx(0, 0, 0, 4096, 0, 0, 0, 4096, 9);         send_tri(0); // tilt past tolerance
		set_vtx(-524288, -524288, 0, 524287, -524288, 0, -524288, 524287, 0); send_tri(0);
		set_vtx(524287, 524287, 524287, -524288, -524288, -524288, 524287, -524288, 524287);
		send_tri(0);
		set_vtx(-524288, 524287, -524288, 524287, -524288, 524287, -524288, -524288, 524287);
		send_tri(1);
		set_vtx(-1, -1, -1, -1, -1, -1, -1, -1, -1);      send_tri(0);
		set_vtx(1, 1, 0, 2, 1, 0, 1, 2, 0);               send_tri(0); // tiniest area
		set_vtx(0, 0, 0, 1, 0, 0, 0, 1, 0);               send_tri(0); // area rounds to zero
		for (int j = 0; j < 6; j++) begin
			gen_noise();
			send_tri(j[0]);
		end
		end_burst();

		// Facing -x at the top of the range, loosest tolerances; long receiver hold here
		set_plane(-16384, 0, 0, 0, 0, 524287, 65535, 16384);
		hold_req = 1;
		random_items(120);

		// +x plane at the bottom of the range, tightest tolerances
		set_plane(16384, 0, 0, -524288, 0, 0, 0, 1);
		random_items(80);
		wait_drained(); // sender waits for every result before going on
		random_items(60);

		// -y plane, zero normal tolerance: nothing may count
		set_plane(0, -16384, 0, 0, rnd_s(524287), 0, $urandom_range(65535), 0);
		random_items(80);

		// Out-of-range normal bit patterns and random points
		set_plane(16'h8000, 16'h7FFF, 16'hFFFF, rnd_s(524287), rnd_s(524287), rnd_s(524287),
			$urandom_range(65535), $urandom_range(32767));
		random_items(60);

		// Diagonal normal with moderate tolerance
		set_plane(11585, 0, 11585, 0, 0, 0, 2000, 200);
		random_items(60);

		// Long run of huge coplanar faces, cleared only at the first: drives the total into saturation
		set_plane(0, 0, 16384, 0, 0, rnd_s(1000), 65535, 16384);
		for (int j = 0; j < 560; j++) begin
			set_vtx(-524288 + $urandom_range(255), -524288, $signed(board.pnt[2]),
				524287 - $urandom_range(255), -524288, $signed(board.pnt[2]),
				-524288, 524287 - $urandom_range(255), $signed(board.pnt[2]));
			send_tri(j == 0);
		end
		end_burst();
		random_items(40);

		wait_drained();
		$display("Checked %0d faces, %0d counted toward the total, %0d saturating adds.",
			board.faces, board.counted, board.saturated);
		$display("Plane settings covered reset, each axis, odd normal codes, tolerance extremes.");
		if (board.errors == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

endmodule

// ----- sim.f -----
+incdir+rtl
rtl/cfsa_pkg.sv
rtl/cfsa_fifo.sv
rtl/cfsa_front.sv
rtl/cfsa_back.sv
rtl/coplanar_face_area_sum_unit.sv
dv/tb_coplanar_face_area_sum_unit.sv
